// ----- rtl/core/arpt_pkg.sv -----
// Shared types and constants for the ARP reply learning table.
package arpt_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

  // Field widths.
  localparam int MAC_BYTES = 6;
  localparam int BITS_PER_BYTE = 8;
  localparam int MAC_W = MAC_BYTES * BITS_PER_BYTE;
  localparam int IP_W = 32;
  localparam int PORT_W = 16;
  localparam int KEY_W = IP_W + PORT_W;

  // Frame codes.
  localparam logic [15:0] ETHTYPE_ARP = 16'h0806;
  localparam logic [15:0] ARP_OP_REPLY = 16'd2;

  // Request function codes.
  localparam logic FUNC_LEARN = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISS    = 2'd3
  } status_e;

  typedef struct packed {
    logic              func;
    logic [PORT_W-1:0] port;
    logic [15:0]       frame_type;
    logic [15:0]       arp_op;
    logic [IP_W-1:0]   ip_address;
    logic [MAC_W-1:0]  sender_mac;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [MAC_W-1:0] found_mac;
  } out_item_t;

  // One table slot as stored in the slot memory.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [MAC_W-1:0] mac;
  } slot_t;

  // Access request from the engine to the slot memory.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_data;
  } mem_req_t;

endpackage

// ----- rtl/core/arp_reply_learning_table.sv -----
// Top level of the ARP reply learning table: engine and slot memory.
//
// Requests enter on the in channel (valid/ready) as one in_item_t: a learn
// carries a received frame's ethertype, opcode, sender IPv4, sender MAC and
// port; a lookup carries IPv4 and port. Every request gives exactly one
// out_item_t on the out channel (valid/ready) with a status and, on a
// lookup hit, the stored MAC.
// One request is worked on at a time. A learn whose frame is not an ARP
// reply is answered without a scan. Any other request reads the filled
// slots from the slot memory, one per cycle, at most TABLE_ENTRIES of
// them; a hit in a slot ends the scan early.
// Slots fill from the bottom and are never freed, so a fill count marks the
// valid entries; reset clears it and the table is empty at once.
// The result waits in an output register; a new request is taken while it
// waits, and the engine holds its next result until the register is free.
module arp_reply_learning_table import arpt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  mem_req_t mem_req;
  slot_t    mem_rdata;

  // Search and update sequencer.
  arpt_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .mem_req_o  (mem_req),
    .mem_rdata_i(mem_rdata)
  );

  // Key and MAC storage.
  arpt_mem u_mem (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rdata_o(mem_rdata)
  );

`ifndef SYNTHESIS
  // The scan and the table update never touch the memory in the same cycle.
  a_no_rd_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.rd_en && mem_req.wr_en))
    else $error("slot memory read and written in one cycle");

  // A request transfer starts work, so the input closes in the next cycle.
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input still ready after a request transfer");

  // The table changes only while a request is in work.
  a_wr_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.wr_en |-> !in_ready_o)
    else $error("slot memory written while idle");
`endif

endmodule

// ----- rtl/core/arpt_mem.sv -----
// Slot memory holding key and MAC of every table entry, with registered read data.
module arpt_mem import arpt_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output slot_t    rdata_o
);

  slot_t mem_q [TABLE_ENTRIES];
  slot_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // Registered read port; the data holds while no read is enabled.
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/arpt_engine.sv -----
// Search sequencer: scans the filled slots, updates the table and registers the result.
module arpt_engine import arpt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o,
  output mem_req_t  mem_req_o,
  input  slot_t     mem_rdata_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FIN  = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             pend_q, pend_d;
  logic             found_q, found_d;
  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] pidx_q, pidx_d;
  logic [IDX_W-1:0] fidx_q, fidx_d;
  logic             func_q, func_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [MAC_W-1:0] mac_q, mac_d;
  out_item_t        res_q, res_d;
  out_item_t        out_item_q, out_item_d;
  logic             in_xfer;
  logic             match;
  logic             issue;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer = in_valid_i && in_ready_o;

  // The entry read in the previous cycle holds the wanted key.
  assign match = (state_q == S_SCAN) && pend_q && (mem_rdata_i.key == key_q);
  // Only filled slots are read; slots fill from the bottom and are never freed.
  assign issue = (state_q == S_SCAN) && (idx_q < cnt_q) && !match;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    pend_d = pend_q;
    found_d = found_q;
    out_valid_d = out_valid_q;
    pidx_d = pidx_q;
    fidx_d = fidx_q;
    func_d = func_q;
    key_d = key_q;
    mac_d = mac_q;
    res_d = res_q;
    out_item_d = out_item_q;
    mem_req_o = '0;

    // The output register empties on its transfer.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          func_d = in_item_i.func;
          key_d = {in_item_i.ip_address, in_item_i.port};
          mac_d = in_item_i.sender_mac;
          idx_d = '0;
          pend_d = 1'b0;
          found_d = 1'b0;
          if (in_item_i.func == FUNC_LEARN &&
              (in_item_i.frame_type != ETHTYPE_ARP ||
               in_item_i.arp_op != ARP_OP_REPLY)) begin
            res_d.status = ST_IGNORED;
            res_d.found_mac = '0;
            state_d = S_RESP;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        mem_req_o.rd_en = issue;
        mem_req_o.rd_addr = idx_q[IDX_W-1:0];
        pend_d = issue;
        if (issue) begin
          idx_d = idx_q + 1'b1;
          pidx_d = idx_q[IDX_W-1:0];
        end
        if (match) begin
          found_d = 1'b1;
          fidx_d = pidx_q;
          state_d = S_FIN;
        end else if (!issue && !pend_q) begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        // The read data still holds the matching entry after a hit.
        res_d.found_mac = '0;
        if (func_q == FUNC_LOOKUP) begin
          if (found_q) begin
            res_d.status = ST_OK;
            res_d.found_mac = mem_rdata_i.mac;
          end else begin
            res_d.status = ST_MISS;
          end
        end else if (found_q) begin
          mem_req_o.wr_en = 1'b1;
          mem_req_o.wr_addr = fidx_q;
          res_d.status = ST_OK;
        end else if (cnt_q != CNT_FULL) begin
          mem_req_o.wr_en = 1'b1;
          mem_req_o.wr_addr = cnt_q[IDX_W-1:0];
          cnt_d = cnt_q + 1'b1;
          res_d.status = ST_OK;
        end else begin
          res_d.status = ST_FULL;
        end
        mem_req_o.wr_data.key = key_q;
        mem_req_o.wr_data.mac = mac_q;
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_item_d = res_q;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      idx_q <= '0;
      pend_q <= 1'b0;
      found_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      pend_q <= pend_d;
      found_q <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    fidx_q <= fidx_d;
    func_q <= func_d;
    key_q <= key_d;
    mac_q <= mac_d;
    res_q <= res_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o = out_item_q;

endmodule
